FILE: hdl/dhb_pkg.sv
// Package with the constants, payload types and helpers of the decimating history buffer.
package dhb_pkg;

   // Store geometry.
   localparam int DEPTH_C = 16;
   localparam int IDX_W   = $clog2(DEPTH_C);
   localparam int CNT_W   = $clog2(DEPTH_C + 1);
   localparam int DATA_W  = 32;

   // Decimation step register.
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(2);

   // The source index can run one full step past the end of the store.
   localparam int SRC_W = $clog2(DEPTH_C + (1 << STEP_W));

   // Item function codes.
   localparam logic FUNC_PUT  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // One input item.
   typedef struct packed {
      logic                     func;
      logic signed [DATA_W-1:0] sample;
      logic [3:0]               read_index;
   } req_type;

   // One result item.
   typedef struct packed {
      logic signed [DATA_W-1:0] read_data;
      logic [4:0]               write_position;
      logic [4:0]               kept_prefix;
      logic                     did_compact;
   } rsp_type;

   // Effective decimation step: values below the minimum act as the minimum.
   function automatic logic [STEP_W-1:0] step_value(input logic [STEP_W-1:0] raw);
      return (raw < STEP_MIN) ? STEP_MIN : raw;
   endfunction

endpackage

FILE: hdl/decimating_history_buffer.sv
// Top level of the decimating history buffer: sample store, compaction sequencer and ports.
//
// The block keeps the last samples in a 16-entry store that never overflows. A put with room
// left writes the store at its transfer and then loads the result register in the done state.
// A read starts the registered read port of the store at its transfer and loads the result
// from it in the done state. A put that finds the store full first compacts it in place: the
// sequencer walks every entry from the compressed prefix to the end of the store with a read
// state and a write state per entry, and a second pass from entry 0 follows when the kept run
// reaches the end. One item is in work at a time. The result register lets the next item be
// taken while a result still waits, and a finished item holds the block while the previous
// result has not yet left. The user must write the decimation step through the csr port only
// while the block is idle; the block itself does not enforce this. 0 and 1 act as 2.
module decimating_history_buffer (
   input  logic                          clock,
   input  logic                          reset,
   // Input items.
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dhb_pkg::req_type              req_data,
   // Results.
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dhb_pkg::rsp_type              rsp_data,
   // Decimation step register.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dhb_pkg::STEP_W-1:0]    csr_data
);
   import dhb_pkg::*;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CRD  = 5'b00010,
      S_CWR  = 5'b00100,
      S_PUT  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   req_type               item_ff, item_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STEP_W-1:0]     csr_ff;
   logic [STEP_W-1:0]     step_eff;
   logic [CNT_W-1:0]      wp_ff, wp_in;
   logic [CNT_W-1:0]      prefix_ff, prefix_in;
   logic [CNT_W-1:0]      kept_ff, kept_in;
   logic [CNT_W-1:0]      kept_next;
   logic [CNT_W-1:0]      start_pos;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [SRC_W-1:0]      src_ff, src_in;
   logic                  src_ok_ff, src_ok_in;
   logic                  pass_ff, pass_in;
   logic                  compact_ff, compact_in;

   // Memory port signals.
   logic [DATA_W-1:0]     store [DEPTH_C];
   logic [DEPTH_C-1:0]    written_ff;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [DATA_W-1:0]     mem_wdata;
   logic                  mem_re;
   logic [IDX_W-1:0]      mem_raddr;
   logic [DATA_W-1:0]     rd_raw_ff;
   logic                  rd_ok_ff;
   logic [DATA_W-1:0]     rd_val;

   // Handshake outputs.
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // Step register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         csr_ff <= csr_data;
      end
   end

   assign step_eff = step_value(csr_ff);

   // An entry that was never written since reset reads as zero.
   assign rd_val = rd_ok_ff ? rd_raw_ff : '0;

   // Compaction starts after the prefix, or from entry 0 once the prefix fills the store.
   assign start_pos = (prefix_ff >= CNT_W'(DEPTH_C)) ? '0 : prefix_ff;
   assign kept_next = kept_ff + CNT_W'(src_ok_ff);

   // Sequencer and memory port control.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wp_in        = wp_ff;
      prefix_in    = prefix_ff;
      kept_in      = kept_ff;
      idx_in       = idx_ff;
      src_in       = src_ff;
      src_ok_in    = src_ok_ff;
      pass_in      = pass_ff;
      compact_in   = compact_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = src_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in    = req_data;
               compact_in = 1'b0;
               if (req_data.func == FUNC_READ) begin
                  // Read: the data comes back from the store next cycle.
                  mem_re    = 1'b1;
                  mem_raddr = req_data.read_index[IDX_W-1:0];
                  state_in  = S_DONE;
               end else if (wp_ff < CNT_W'(DEPTH_C)) begin
                  // Put with room left: one write.
                  mem_we    = 1'b1;
                  mem_waddr = wp_ff[IDX_W-1:0];
                  mem_wdata = req_data.sample;
                  wp_in     = wp_ff + CNT_W'(1);
                  state_in  = S_DONE;
               end else begin
                  // Put into a full store: compact first.
                  idx_in     = start_pos[IDX_W-1:0];
                  src_in     = SRC_W'(start_pos);
                  kept_in    = start_pos;
                  pass_in    = 1'b0;
                  compact_in = 1'b1;
                  state_in   = S_CRD;
               end
            end
         end

         S_CRD: begin
            // Fetch the next kept sample, if the source is still inside the store.
            src_ok_in = (src_ff < SRC_W'(DEPTH_C));
            mem_re    = src_ok_in;
            state_in  = S_CWR;
         end

         S_CWR: begin
            // Move the kept sample down, or zero the freed tail. The source index
            // never falls behind the destination, so no read sees an earlier write.
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = src_ok_ff ? rd_val : '0;
            kept_in   = kept_next;
            if (src_ok_ff) begin
               src_in = src_ff + SRC_W'(step_eff);
            end
            if (idx_ff == IDX_W'(DEPTH_C - 1)) begin
               if ((kept_next == CNT_W'(DEPTH_C)) && !pass_ff) begin
                  // No free slot left: one more pass from entry 0.
                  idx_in   = '0;
                  src_in   = '0;
                  kept_in  = '0;
                  pass_in  = 1'b1;
                  state_in = S_CRD;
               end else begin
                  prefix_in = kept_next;
                  wp_in     = kept_next;
                  state_in  = S_PUT;
               end
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_CRD;
            end
         end

         S_PUT: begin
            // Write the sample right after the kept run.
            if (wp_ff < CNT_W'(DEPTH_C)) begin
               mem_we    = 1'b1;
               mem_waddr = wp_ff[IDX_W-1:0];
               mem_wdata = item_ff.sample;
               wp_in     = wp_ff + CNT_W'(1);
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            // Load the result register once it is free or being drained.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.read_data      = (item_ff.func == FUNC_READ) ? rd_val : item_ff.sample;
               rsp_in.write_position = wp_ff;
               rsp_in.kept_prefix    = prefix_ff;
               rsp_in.did_compact    = compact_ff;
               state_in              = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= '0;
         prefix_ff    <= '0;
         pass_ff      <= 1'b0;
         written_ff   <= '0;
         rd_ok_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wp_ff        <= wp_in;
         prefix_ff    <= prefix_in;
         pass_ff      <= pass_in;
         if (mem_we) begin
            written_ff[mem_waddr] <= 1'b1;
         end
         if (mem_re) begin
            rd_ok_ff <= written_ff[mem_raddr];
         end
      end
   end

   // Payload and walk registers.
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      rsp_ff     <= rsp_in;
      kept_ff    <= kept_in;
      idx_ff     <= idx_in;
      src_ff     <= src_in;
      src_ok_ff  <= src_ok_in;
      compact_ff <= compact_in;
   end

   // Sample store with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_raw_ff <= store[mem_raddr];
      end
   end

`ifndef SYNTHESIS
   // The write position never runs past the end of the store.
   assert property (@(posedge clock) disable iff (reset) wp_ff <= CNT_W'(DEPTH_C))
      else $error("write position beyond the store");

   // The compressed prefix never lies beyond the write position.
   assert property (@(posedge clock) disable iff (reset) prefix_ff <= wp_ff)
      else $error("prefix beyond the write position");

   // A compacting put lands right after the kept run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.did_compact) |->
         (rsp_ff.write_position == rsp_ff.kept_prefix + 5'd1))
      else $error("compacting put not written after the kept run");

   // An accepted item always leaves the idle state.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted item not taken into work");
`endif

endmodule

FILE: sim/decimating_history_buffer_test.sv
// Self-checking testbench of the decimating history buffer with a predicting scoreboard.
`timescale 1ns / 1ps

module decimating_history_buffer_test;
   import dhb_pkg::*;

   // Tracks the store contents, predicts the result of each input transfer and checks each
   // result.
   class history_scoreboard;
      logic [DATA_W-1:0] store [DEPTH_C];
      logic [4:0]        write_ptr;
      logic [4:0]        prefix_len;
      logic [STEP_W-1:0] step_reg;
      rsp_type           expected_q [$];
      int                errors;
      int                puts;
      int                reads;
      int                compactions;
      int                repairs;

      function new();
         foreach (store[i]) store[i] = '0;
         write_ptr   = '0;
         prefix_len  = '0;
         step_reg    = STEP_RESET;
         errors      = 0;
         puts        = 0;
         reads       = 0;
         compactions = 0;
         repairs     = 0;
      endfunction

      function void set_step(logic [STEP_W-1:0] value);
         step_reg = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // One compaction pass: keep every step-th entry after the prefix and zero the tail.
      function void compact_pass();
         int eff;
         int kept;
         int src;
         eff = (step_reg < STEP_MIN) ? int'(STEP_MIN) : int'(step_reg);
         // A prefix that covers the whole store starts over from entry 0.
         if (prefix_len >= DEPTH_C) prefix_len = '0;
         kept = int'(prefix_len);
         src  = int'(prefix_len);
         for (int i = int'(prefix_len); i < DEPTH_C; i++) begin
            if (src < DEPTH_C) begin
               store[i] = store[src];
               src += eff;
               kept++;
            end else begin
               store[i] = '0;
            end
         end
         prefix_len = kept[4:0];
         write_ptr  = kept[4:0];
      endfunction

      // Work out the result of one accepted input transfer.
      function void note_request(req_type item);
         rsp_type exp;
         exp = '0;
         if (item.func == FUNC_PUT) begin
            puts++;
            if (write_ptr >= DEPTH_C) begin
               compact_pass();
               // A kept run that reaches the end leaves no room, so compact again from entry 0.
               if (write_ptr >= DEPTH_C) begin
                  compact_pass();
                  repairs++;
               end
               exp.did_compact = 1'b1;
               compactions++;
            end
            store[write_ptr[IDX_W-1:0]] = item.sample;
            write_ptr++;
            exp.read_data = item.sample;
         end else begin
            reads++;
            exp.read_data = store[item.read_index];
         end
         exp.write_position = write_ptr;
         exp.kept_prefix    = prefix_len;
         expected_q.push_back(exp);
      endfunction

      // Compare one result transfer with the oldest prediction.
      function void check_response(rsp_type got);
         rsp_type exp;
         if (expected_q.size() == 0) begin
            $display("%0t: result with no prediction waiting: %p", $time, got);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.read_data !== exp.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, exp.read_data,
                     got.read_data);
            errors++;
         end
         if (got.write_position !== exp.write_position) begin
            $display("%0t: write_position expected %0d actual %0d", $time,
                     exp.write_position, got.write_position);
            errors++;
         end
         if (got.kept_prefix !== exp.kept_prefix) begin
            $display("%0t: kept_prefix expected %0d actual %0d", $time,
                     exp.kept_prefix, got.kept_prefix);
            errors++;
         end
         if (got.did_compact !== exp.did_compact) begin
            $display("%0t: did_compact expected %b actual %b", $time,
                     exp.did_compact, got.did_compact);
            errors++;
         end
      endfunction
   endclass

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 4;
   localparam int PHASE_ITEMS    = 100;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 80;
   localparam int RUN_LIMIT_NS   = 4_000_000;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [STEP_W-1:0] csr_data  = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int settings_run  = 0;

   history_scoreboard sb = new();

   decimating_history_buffer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // The result side stalls at random according to the current idle rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Every transfer is observed at the clock edge that completes it.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_step(csr_data);
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // Present one item and hold it until its transfer, then maybe leave a gap.
   task automatic send_item(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Stop sending and wait until every predicted result has arrived.
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Write the decimation step while the block is idle.
   task automatic write_step(input logic [STEP_W-1:0] value);
      drain(SETTLE_CYCLES);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   function automatic req_type make_item(input logic func, input logic [DATA_W-1:0] value,
                                         input logic [IDX_W-1:0] index);
      req_type item;
      item.func       = func;
      item.sample     = value;
      item.read_index = index;
      return item;
   endfunction

   // Random content: mostly puts, with the sample extremes showing up often.
   function automatic req_type random_item();
      logic [DATA_W-1:0] value;
      case ($urandom_range(7))
         0:       value = 32'h7FFF_FFFF;
         1:       value = 32'h8000_0000;
         2:       value = '1;
         3:       value = '0;
         default: value = $urandom();
      endcase
      return make_item(($urandom_range(3) == 0) ? FUNC_READ : FUNC_PUT, value,
                       IDX_W'($urandom_range(DEPTH_C - 1)));
   endfunction

   // Run limit, far above the slowest correct run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: run limit reached", $time);
      $display("decimating_history_buffer regression: fail");
      $finish;
   end

   initial begin
      logic [STEP_W-1:0] steps [9];

      steps = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd7, 5'd1, 5'd2, 5'd5, 5'd16};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at the reset step: reads of the cleared store and the sample extremes.
      send_idle_pct = 23;
      recv_idle_pct = 64;
      send_item(make_item(FUNC_READ, $urandom(), 4'd0));
      send_item(make_item(FUNC_READ, $urandom(), 4'd15));
      send_item(make_item(FUNC_PUT, 32'h7FFF_FFFF, 4'd15));
      send_item(make_item(FUNC_PUT, 32'h8000_0000, 4'd0));
      send_item(make_item(FUNC_PUT, '1, IDX_W'($urandom())));
      send_item(make_item(FUNC_PUT, '0, IDX_W'($urandom())));
      send_item(make_item(FUNC_PUT, 32'hAAAA_AAAA, IDX_W'($urandom())));
      send_item(make_item(FUNC_PUT, 32'h5555_5555, IDX_W'($urandom())));
      send_item(make_item(FUNC_READ, '1, 4'd0));
      send_item(make_item(FUNC_READ, '0, 4'd1));
      send_item(make_item(FUNC_READ, $urandom(), 4'd5));
      send_item(make_item(FUNC_READ, $urandom(), 4'd6));
      // Fill the store; the last put of this loop finds it full and compacts it.
      for (int i = 0; i < 11; i++) begin
         send_item(make_item(FUNC_PUT, $urandom(), IDX_W'($urandom())));
      end
      send_item(make_item(FUNC_READ, $urandom(), 4'd15));
      send_item(make_item(FUNC_PUT, 32'h1234_5678, IDX_W'($urandom())));

      // Random phases, each after a step write, with the idle pattern changing every three phases.
      foreach (steps[p]) begin
         write_step(steps[p]);
         case (p / 3)
            0: begin send_idle_pct = 23; recv_idle_pct = 64; end
            1: begin send_idle_pct = 64; recv_idle_pct = 23; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
      end

      drain(TAIL_CYCLES);
      $display("Covered %0d puts and %0d reads under %0d step settings.",
               sb.puts, sb.reads, settings_run + 1);
      $display("%0d puts compacted the store, %0d of them with a second pass from entry 0.",
               sb.compactions, sb.repairs);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("decimating_history_buffer regression: pass");
      end else begin
         $display("decimating_history_buffer regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/dhb_pkg.sv
hdl/decimating_history_buffer.sv
sim/decimating_history_buffer_test.sv
